// File: rtl/core/mhs_pkg.sv
// Shared constants, types and tables for the magnetometer heading sector unit.
`default_nettype none

package mhs_pkg;

  // Iteration count of the vectoring pipeline
  localparam int ANGLE_ITERATIONS_DEF = 20;
  localparam int ITER_MAX             = 32;

  // Field widths
  localparam int MAG_W   = 16;
  localparam int WHOLE_W = 9;
  localparam int HUND_W  = 7;
  localparam int SECT_W  = 3;

  // Fixed-point formats: vector in units of 2^-16, angle in units of 2^-24 degree
  localparam int IN_SCALE = 16;
  localparam int ANG_FRAC = 24;
  localparam int XY_W     = 36;
  localparam int Z_W      = 36;
  localparam int ZU_W     = 33;
  localparam int PROD_W   = 40;
  localparam int TOTAL_W  = 16;
  localparam int EST_W    = 10;
  localparam int RECIP_W  = 32;
  localparam int REM_W    = 16;

  typedef logic signed [XY_W-1:0] xy_t;
  typedef logic signed [Z_W-1:0]  ang_t;

  localparam ang_t QUARTER_TURN = ang_t'(64'd90  << ANG_FRAC);
  localparam ang_t HALF_TURN    = ang_t'(64'd180 << ANG_FRAC);
  localparam ang_t THREE_QUARTER_TURN = ang_t'(64'd270 << ANG_FRAC);
  localparam ang_t FULL_TURN    = ang_t'(64'd360 << ANG_FRAC);

  // Hundredths split: multiply by floor(2^22/100), then correct once
  localparam int                 HUND_PER_DEG = 100;
  localparam logic [TOTAL_W-1:0] RECIP_100    = 16'd41943;
  localparam int                 RECIP_SHIFT  = 22;

  // Axis codes for exact angles
  localparam logic [1:0] AXIS_0   = 2'd0;
  localparam logic [1:0] AXIS_90  = 2'd1;
  localparam logic [1:0] AXIS_180 = 2'd2;
  localparam logic [1:0] AXIS_270 = 2'd3;

  // Sector codes
  localparam logic [SECT_W-1:0] SECTOR_N  = 3'd0;
  localparam logic [SECT_W-1:0] SECTOR_NE = 3'd1;
  localparam logic [SECT_W-1:0] SECTOR_E  = 3'd2;
  localparam logic [SECT_W-1:0] SECTOR_SE = 3'd3;
  localparam logic [SECT_W-1:0] SECTOR_S  = 3'd4;
  localparam logic [SECT_W-1:0] SECTOR_SW = 3'd5;
  localparam logic [SECT_W-1:0] SECTOR_W  = 3'd6;
  localparam logic [SECT_W-1:0] SECTOR_NW = 3'd7;

  // Sector boundaries in whole degrees (last degree of each sector; BOUND_N_HI is the first degree of north)
  localparam logic [WHOLE_W-1:0] BOUND_N_LO = 9'd22;
  localparam logic [WHOLE_W-1:0] BOUND_NE   = 9'd67;
  localparam logic [WHOLE_W-1:0] BOUND_E    = 9'd112;
  localparam logic [WHOLE_W-1:0] BOUND_SE   = 9'd157;
  localparam logic [WHOLE_W-1:0] BOUND_S    = 9'd202;
  localparam logic [WHOLE_W-1:0] BOUND_SW   = 9'd247;
  localparam logic [WHOLE_W-1:0] BOUND_W    = 9'd292;
  localparam logic [WHOLE_W-1:0] BOUND_N_HI = 9'd338;
  localparam logic [WHOLE_W-1:0] DEG_FULL   = 9'd360;

  // atan(2^-i) in degrees times 2^24, rounded to nearest
  localparam logic [29:0] ATAN_ROM [ITER_MAX] = '{
    30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938,
    30'd60000934,  30'd30029717,  30'd15018523,  30'd7509720,
    30'd3754917,   30'd1877466,   30'd938734,    30'd469367,
    30'd234684,    30'd117342,    30'd58671,     30'd29335,
    30'd14668,     30'd7334,      30'd3667,      30'd1833,
    30'd917,       30'd458,       30'd229,       30'd115,
    30'd57,        30'd29,        30'd14,        30'd7,
    30'd4,         30'd2,         30'd1,         30'd0
  };

  function automatic ang_t atan_entry(input logic [4:0] idx);
    atan_entry = ang_t'(ATAN_ROM[idx]);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/magnetometer_heading_sector_unit.sv
// Top level: pipelined vectoring heading unit with hundredths split and sector decode.
// Pipeline: an entry stage, one stage per micro-rotation, then fold, scale, divide,
// correct and decode stages. Throughput: one request per cycle; busy is always low.
// Results show on the result ports for one cycle with done; the receiver cannot stall.
// Reset (rst, synchronous, active high) clears all valid bits; data registers keep contents.
`default_nettype none

module magnetometer_heading_sector_unit #(
  parameter int ANGLE_ITERATIONS = mhs_pkg::ANGLE_ITERATIONS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic signed [mhs_pkg::MAG_W-1:0]    mag_x,
  input  wire logic signed [mhs_pkg::MAG_W-1:0]    mag_y,
  output logic                                     done,
  output logic [mhs_pkg::WHOLE_W-1:0]              heading_whole,
  output logic [mhs_pkg::HUND_W-1:0]               heading_hundredths,
  output logic [mhs_pkg::SECT_W-1:0]               sector
);

  localparam int ITER    = ANGLE_ITERATIONS;
  localparam int LATENCY = ITER + 6;

  // Micro-rotation pipeline, entry stage at index 0
  logic                    vld_pipe  [0:ITER];
  mhs_pkg::xy_t            x_pipe    [0:ITER];
  mhs_pkg::xy_t            y_pipe    [0:ITER];
  mhs_pkg::ang_t           z_pipe    [0:ITER];
  logic                    spc_pipe  [0:ITER];
  logic [1:0]              axis_pipe [0:ITER];

  // Entry stage signals
  mhs_pkg::xy_t            x_ext;
  mhs_pkg::xy_t            y_ext;
  logic                    x_neg;
  logic                    x_zero;
  logic                    y_zero;
  logic [1:0]              axis_next;

  // Back-end stages
  logic                              f_vld;
  logic [mhs_pkg::ZU_W-1:0]          f_z;
  mhs_pkg::ang_t                     z_fold_next;
  mhs_pkg::ang_t                     z_axis;
  logic                              m_vld;
  logic [mhs_pkg::TOTAL_W-1:0]       m_total;
  logic [mhs_pkg::PROD_W-1:0]        m_prod;
  logic                              d_vld;
  logic [mhs_pkg::TOTAL_W-1:0]       d_total;
  logic [mhs_pkg::EST_W-1:0]         d_est;
  logic [mhs_pkg::RECIP_W-1:0]       d_prod;
  logic                              c_vld;
  logic [mhs_pkg::WHOLE_W-1:0]       c_whole;
  logic [mhs_pkg::HUND_W-1:0]        c_hund;
  logic [mhs_pkg::REM_W-1:0]         c_rem;
  logic [mhs_pkg::SECT_W-1:0]        sector_next;

  // Never hold off requests
  assign busy = 1'b0;

  // Classify the sample and fold the left half-plane onto the right
  assign x_ext  = mhs_pkg::xy_t'(mag_x);
  assign y_ext  = mhs_pkg::xy_t'(mag_y);
  assign x_neg  = mag_x[mhs_pkg::MAG_W-1];
  assign x_zero = (mag_x == '0);
  assign y_zero = (mag_y == '0);

  always_comb begin
    if (y_zero) begin
      axis_next = x_neg ? mhs_pkg::AXIS_180 : mhs_pkg::AXIS_0;
    end else if (mag_y[mhs_pkg::MAG_W-1]) begin
      axis_next = mhs_pkg::AXIS_270;
    end else begin
      axis_next = mhs_pkg::AXIS_90;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_pipe[0] <= 1'b0;
    end else begin
      vld_pipe[0] <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    x_pipe[0]    <= (x_neg ? -x_ext : x_ext) <<< mhs_pkg::IN_SCALE;
    y_pipe[0]    <= (x_neg ? -y_ext : y_ext) <<< mhs_pkg::IN_SCALE;
    z_pipe[0]    <= x_neg ? mhs_pkg::HALF_TURN : '0;
    spc_pipe[0]  <= x_zero || y_zero;
    axis_pipe[0] <= axis_next;
  end

  // One micro-rotation per stage, driving y toward zero
  for (genvar i = 0; i < ITER; i++) begin : g_rot
    mhs_pkg::xy_t  x_sh;
    mhs_pkg::xy_t  y_sh;
    mhs_pkg::ang_t atan_i;

    assign x_sh   = x_pipe[i] >>> i;
    assign y_sh   = y_pipe[i] >>> i;
    assign atan_i = mhs_pkg::atan_entry(5'(i));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_pipe[i+1] <= 1'b0;
      end else begin
        vld_pipe[i+1] <= vld_pipe[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!y_pipe[i][mhs_pkg::XY_W-1]) begin
        x_pipe[i+1] <= x_pipe[i] + y_sh;
        y_pipe[i+1] <= y_pipe[i] - x_sh;
        z_pipe[i+1] <= z_pipe[i] + atan_i;
      end else begin
        x_pipe[i+1] <= x_pipe[i] - y_sh;
        y_pipe[i+1] <= y_pipe[i] + x_sh;
        z_pipe[i+1] <= z_pipe[i] - atan_i;
      end
      spc_pipe[i+1]  <= spc_pipe[i];
      axis_pipe[i+1] <= axis_pipe[i];
    end
  end

  // Fold the angle into one turn, or take the exact axis angle
  always_comb begin
    unique case (axis_pipe[ITER])
      mhs_pkg::AXIS_0:   z_axis = '0;
      mhs_pkg::AXIS_90:  z_axis = mhs_pkg::QUARTER_TURN;
      mhs_pkg::AXIS_180: z_axis = mhs_pkg::HALF_TURN;
      mhs_pkg::AXIS_270: z_axis = mhs_pkg::THREE_QUARTER_TURN;
      default:           z_axis = '0;
    endcase
    if (spc_pipe[ITER]) begin
      z_fold_next = z_axis;
    end else if (z_pipe[ITER][mhs_pkg::Z_W-1]) begin
      z_fold_next = z_pipe[ITER] + mhs_pkg::FULL_TURN;
    end else if (z_pipe[ITER] >= mhs_pkg::FULL_TURN) begin
      z_fold_next = z_pipe[ITER] - mhs_pkg::FULL_TURN;
    end else begin
      z_fold_next = z_pipe[ITER];
    end
  end

  // Scale to hundredths of a degree
  assign m_prod = mhs_pkg::PROD_W'(f_z) * mhs_pkg::PROD_W'(mhs_pkg::HUND_PER_DEG);

  // Estimate whole degrees by reciprocal multiply
  assign d_prod = mhs_pkg::RECIP_W'(m_total) * mhs_pkg::RECIP_W'(mhs_pkg::RECIP_100);

  // Correct the estimate, which may be one low
  assign c_rem = d_total - mhs_pkg::REM_W'(d_est) * mhs_pkg::REM_W'(mhs_pkg::HUND_PER_DEG);

  // Decode the sector from whole degrees
  always_comb begin
    if (c_whole >= mhs_pkg::BOUND_N_HI || c_whole <= mhs_pkg::BOUND_N_LO) begin
      sector_next = mhs_pkg::SECTOR_N;
    end else if (c_whole <= mhs_pkg::BOUND_NE) begin
      sector_next = mhs_pkg::SECTOR_NE;
    end else if (c_whole <= mhs_pkg::BOUND_E) begin
      sector_next = mhs_pkg::SECTOR_E;
    end else if (c_whole <= mhs_pkg::BOUND_SE) begin
      sector_next = mhs_pkg::SECTOR_SE;
    end else if (c_whole <= mhs_pkg::BOUND_S) begin
      sector_next = mhs_pkg::SECTOR_S;
    end else if (c_whole <= mhs_pkg::BOUND_SW) begin
      sector_next = mhs_pkg::SECTOR_SW;
    end else if (c_whole <= mhs_pkg::BOUND_W) begin
      sector_next = mhs_pkg::SECTOR_W;
    end else begin
      sector_next = mhs_pkg::SECTOR_NW;
    end
  end

  // Advance valid bits through the back end
  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
      m_vld <= 1'b0;
      d_vld <= 1'b0;
      c_vld <= 1'b0;
      done  <= 1'b0;
    end else begin
      f_vld <= vld_pipe[ITER];
      m_vld <= f_vld;
      d_vld <= m_vld;
      c_vld <= d_vld;
      done  <= c_vld;
    end
  end

  // Back-end data registers
  always_ff @(posedge clk) begin
    f_z     <= z_fold_next[mhs_pkg::ZU_W-1:0];
    m_total <= m_prod[mhs_pkg::ANG_FRAC +: mhs_pkg::TOTAL_W];
    d_total <= m_total;
    d_est   <= d_prod[mhs_pkg::RECIP_SHIFT +: mhs_pkg::EST_W];
    if (c_rem >= mhs_pkg::REM_W'(mhs_pkg::HUND_PER_DEG)) begin
      c_whole <= mhs_pkg::WHOLE_W'(d_est + 1'b1);
      c_hund  <= mhs_pkg::HUND_W'(c_rem - mhs_pkg::REM_W'(mhs_pkg::HUND_PER_DEG));
    end else begin
      c_whole <= mhs_pkg::WHOLE_W'(d_est);
      c_hund  <= mhs_pkg::HUND_W'(c_rem);
    end
    heading_whole      <= c_whole;
    heading_hundredths <= c_hund;
    sector             <= sector_next;
  end

  // Every request returns after the fixed pipeline depth
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LATENCY done)
    else $error("request did not complete after pipeline latency");

  // Result stays within one turn and one degree of hundredths
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (heading_whole < mhs_pkg::DEG_FULL) && (heading_hundredths < 7'd100))
    else $error("heading out of range");

  // North covers the low end of the turn
  a_north: assert property (@(posedge clk) disable iff (rst)
    done && heading_whole <= mhs_pkg::BOUND_N_LO |-> sector == mhs_pkg::SECTOR_N)
    else $error("sector disagrees with heading near zero");

  // East sector matches its degree span
  a_east: assert property (@(posedge clk) disable iff (rst)
    done && sector == mhs_pkg::SECTOR_E |->
      heading_whole > mhs_pkg::BOUND_NE && heading_whole <= mhs_pkg::BOUND_E)
    else $error("east sector outside its span");

endmodule

`default_nettype wire
